// ===== rtl/skt_pkg.sv =====
// shared types and constants of the sorted key table
// no dependencies; imported by the engine and the top level
`timescale 1ns / 1ps

package skt_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 16;
    localparam int KEY_W        = 16;
    localparam int PAY_W        = 32;
    localparam int ENT_W        = 5;

    typedef enum logic [2:0] {
        OP_INSERT    = 3'd0,
        OP_DELETE    = 3'd1,
        OP_LOOKUP    = 3'd2,
        OP_LIST_ASC  = 3'd3,
        OP_LIST_DESC = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_DUP      = 3'd1,
        STS_FULL     = 3'd2,
        STS_NOTFOUND = 3'd3,
        STS_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHUP,
        ST_SHDN,
        ST_WRNEW,
        ST_RESP,
        ST_LIST_RD,
        ST_LIST_OUT
    } t_state;

    typedef struct packed {
        t_status            status;
        logic [KEY_W-1:0]   key;
        logic [PAY_W-1:0]   payload;
        logic [ENT_W-1:0]   entries;
        logic               last;
    } t_res;

endpackage

// ===== rtl/skt_ram.sv =====
// generic single-clock ram, one write port and one read port, registered read
// no dependencies
`timescale 1ns / 1ps

module skt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/skt_engine.sv =====
// sequencer of the sorted key table: scan, shift, insert, delete and listing
// uses skt_pkg; drives the entry ram and hands results to the output register
`timescale 1ns / 1ps

module skt_engine
    import skt_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int KW       = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [2:0]               i_op,
    input  logic [KEY_W-1:0]         i_key,
    input  logic [PAY_W-1:0]         i_payload,
    output logic                     o_push,
    output t_res                     o_res,
    input  logic                     i_slot_free,
    output logic                     o_we,
    output logic [$clog2(DEPTH)-1:0] o_waddr,
    output logic [KW+PAY_W-1:0]      o_wdata,
    output logic                     o_re,
    output logic [$clog2(DEPTH)-1:0] o_raddr,
    input  logic [KW+PAY_W-1:0]      i_rdata
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic [KW-1:0]    r_key, n_key;
    logic [PAY_W-1:0] r_pay, n_pay;
    logic [CW-1:0]    r_fill, n_fill;
    logic [IW-1:0]    r_ri, n_ri;
    logic             r_go, n_go;
    logic             r_dv, n_dv;
    logic [IW-1:0]    r_ci, n_ci;
    logic [IW-1:0]    r_pos, n_pos;
    t_status          r_sts, n_sts;
    logic [KW-1:0]    r_okey, n_okey;
    logic [PAY_W-1:0] r_opay, n_opay;

    logic [KW-1:0]    rd_key;
    logic [PAY_W-1:0] rd_pay;
    logic [CW-1:0]    fill_m1;
    logic             hit, found, at_end, list_last;

    assign rd_key    = i_rdata[KW+PAY_W-1:PAY_W];
    assign rd_pay    = i_rdata[PAY_W-1:0];
    assign fill_m1   = r_fill - 1'b1;
    // first stored key not below the search key, or the end of the table
    assign hit       = r_dv && (rd_key >= r_key);
    assign found     = hit && (rd_key == r_key);
    assign at_end    = r_dv && (CW'(r_ci) == fill_m1);
    assign list_last = (CW'(r_ri) == fill_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_go    <= 1'b0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_go    <= n_go;
            r_dv    <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_key  <= n_key;
        r_pay  <= n_pay;
        r_ri   <= n_ri;
        r_ci   <= n_ci;
        r_pos  <= n_pos;
        r_sts  <= n_sts;
        r_okey <= n_okey;
        r_opay <= n_opay;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_key   = r_key;
        n_pay   = r_pay;
        n_fill  = r_fill;
        n_ri    = r_ri;
        n_go    = r_go;
        n_dv    = 1'b0;
        n_ci    = r_ci;
        n_pos   = r_pos;
        n_sts   = r_sts;
        n_okey  = r_okey;
        n_opay  = r_opay;
        o_ready = 1'b0;
        o_push  = 1'b0;
        o_res   = '{status: r_sts, key: KEY_W'(r_okey), payload: r_opay,
                    entries: ENT_W'(r_fill), last: 1'b1};
        o_we    = 1'b0;
        o_waddr = r_pos;
        o_wdata = i_rdata;
        o_re    = 1'b0;
        o_raddr = r_ri;

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op  = t_op'(i_op);
                    n_key = i_key[KW-1:0];
                    n_pay = i_payload;
                    n_ri  = '0;
                    n_go  = 1'b1;
                    n_pos = '0;
                    unique case (t_op'(i_op)) inside
                        OP_INSERT: begin
                            n_state = (r_fill == '0) ? ST_WRNEW : ST_SCAN;
                        end
                        OP_DELETE: begin
                            if (r_fill == '0) begin
                                n_sts   = STS_NOTFOUND;
                                n_okey  = '0;
                                n_opay  = '0;
                                n_state = ST_RESP;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_LOOKUP, OP_LIST_ASC, OP_LIST_DESC: begin
                            if (r_fill == '0) begin
                                n_sts   = STS_EMPTY;
                                n_okey  = '0;
                                n_opay  = '0;
                                n_state = ST_RESP;
                            end else if (t_op'(i_op) == OP_LOOKUP) begin
                                n_state = ST_SCAN;
                            end else begin
                                n_state = ST_LIST_RD;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // one read issued per cycle, compare on the returning data
                if (r_go) begin
                    o_re = 1'b1;
                    n_dv = 1'b1;
                    n_ci = r_ri;
                    if (CW'(r_ri) == fill_m1) begin
                        n_go = 1'b0;
                    end else begin
                        n_ri = r_ri + 1'b1;
                    end
                end
                if (hit || at_end) begin
                    n_go  = 1'b0;
                    n_dv  = 1'b0;
                    n_pos = hit ? r_ci : r_fill[IW-1:0];
                    n_okey = rd_key;
                    n_opay = rd_pay;
                    n_state = ST_RESP;
                    unique case (r_op)
                        OP_INSERT: begin
                            if (found) begin
                                n_sts = STS_DUP;
                            end else if (r_fill == CW'(DEPTH)) begin
                                n_sts  = STS_FULL;
                                n_okey = '0;
                                n_opay = '0;
                            end else if (!hit) begin
                                n_state = ST_WRNEW;
                            end else begin
                                n_ri    = fill_m1[IW-1:0];
                                n_go    = 1'b1;
                                n_state = ST_SHUP;
                            end
                        end
                        OP_DELETE: begin
                            if (!found) begin
                                n_sts  = STS_NOTFOUND;
                                n_okey = '0;
                                n_opay = '0;
                            end else begin
                                n_sts = STS_OK;
                                if (CW'(r_ci) == fill_m1) begin
                                    n_fill = fill_m1;
                                end else begin
                                    n_ri    = r_ci + 1'b1;
                                    n_go    = 1'b1;
                                    n_state = ST_SHDN;
                                end
                            end
                        end
                        default: begin
                            if (found) begin
                                n_sts = STS_OK;
                            end else begin
                                n_sts  = STS_NOTFOUND;
                                n_okey = '0;
                                n_opay = '0;
                            end
                        end
                    endcase
                end
            end

            ST_SHUP: begin
                // move entries pos..fill-1 up by one, from the top down
                if (r_go) begin
                    o_re = 1'b1;
                    n_dv = 1'b1;
                    n_ci = r_ri;
                    if (r_ri == r_pos) begin
                        n_go = 1'b0;
                    end else begin
                        n_ri = r_ri - 1'b1;
                    end
                end
                if (r_dv) begin
                    o_we    = 1'b1;
                    o_waddr = r_ci + 1'b1;
                end
                if (!r_go && !r_dv) begin
                    n_state = ST_WRNEW;
                end
            end

            ST_WRNEW: begin
                o_we    = 1'b1;
                o_waddr = r_pos;
                o_wdata = {r_key, r_pay};
                n_fill  = r_fill + 1'b1;
                n_sts   = STS_OK;
                n_okey  = r_key;
                n_opay  = r_pay;
                n_state = ST_RESP;
            end

            ST_SHDN: begin
                // move entries pos+1..fill-1 down by one, from the bottom up
                if (r_go) begin
                    o_re = 1'b1;
                    n_dv = 1'b1;
                    n_ci = r_ri;
                    if (CW'(r_ri) == fill_m1) begin
                        n_go = 1'b0;
                    end else begin
                        n_ri = r_ri + 1'b1;
                    end
                end
                if (r_dv) begin
                    o_we    = 1'b1;
                    o_waddr = r_ci - 1'b1;
                end
                if (!r_go && !r_dv) begin
                    n_fill  = fill_m1;
                    n_state = ST_RESP;
                end
            end

            ST_RESP: begin
                o_push = i_slot_free;
                if (i_slot_free) begin
                    n_state = ST_IDLE;
                end
            end

            ST_LIST_RD: begin
                o_re    = 1'b1;
                o_raddr = (r_op == OP_LIST_ASC) ? r_ri : (fill_m1[IW-1:0] - r_ri);
                n_state = ST_LIST_OUT;
            end

            ST_LIST_OUT: begin
                o_res = '{status: STS_OK, key: KEY_W'(rd_key), payload: rd_pay,
                          entries: ENT_W'(r_fill), last: list_last};
                o_push = i_slot_free;
                if (i_slot_free) begin
                    if (list_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_ri    = r_ri + 1'b1;
                        n_state = ST_LIST_RD;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we && o_re) |-> (o_waddr != o_raddr))
        else $error("read and write of the same entry in one cycle");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_res.last) |=> (r_state == ST_IDLE))
        else $error("final beat did not return the sequencer to idle");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRNEW) |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("insert did not grow the table");

endmodule

// ===== rtl/sorted_key_table.sv =====
// Sorted key table: keeps up to DEPTH unique keys in ascending order, each with a
// 32-bit payload, in one entry ram; one input beat is one operation (insert,
// delete, lookup, list ascending, list descending). Lookup, insert and delete
// scan the ram one entry per cycle until the first key not below the search key
// or the end of the table; insert then moves the entries from that point up, and
// delete those above it, one per cycle, since the ram has a single read and a
// single write port. Listing reads each entry from the ram, then hands it out as
// a result beat, and reads the next only once the output has taken that beat. A
// new operation is taken only after the previous one has handed its last result
// to the output register. Unknown op codes are consumed without a result.
// uses skt_pkg, skt_ram and skt_engine
`timescale 1ns / 1ps

module sorted_key_table
    import skt_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // key[15:0], payload[47:16]
    input  logic [2:0]  s_axis_tuser,   // op[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_key[15:0], out_payload[47:16],
                                        // entries[52:48], zero fill[55:53]
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    output logic        m_axis_tlast
);

    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int DW = KW + PAY_W;
    localparam int AW = $clog2(DEPTH);

    logic          push, slot_free;
    t_res          res;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;

    logic          r_mv;
    t_res          r_mres;

    skt_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    skt_engine #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_key       (s_axis_tdata[KEY_W-1:0]),
        .i_payload   (s_axis_tdata[KEY_W+PAY_W-1:KEY_W]),
        .o_push      (push),
        .o_res       (res),
        .i_slot_free (slot_free),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    // output register: a held beat frees the slot in the cycle it is taken
    assign slot_free = !r_mv || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (push) begin
            r_mv <= 1'b1;
        end else if (m_axis_tready) begin
            r_mv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mres <= res;
        end
    end

    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = {3'b000, r_mres.entries, r_mres.payload, r_mres.key};
    assign m_axis_tuser  = r_mres.status;
    assign m_axis_tlast  = r_mres.last;

endmodule
